// File: rtl/core/gqor_pkg.sv
// Shared types and constants for the group quantile overlap range block.
package gqor_pkg;

	localparam int MAX_SAMPLES = 65536;
	localparam int VAL_W = 32;
	localparam int VAR_W = 8;
	// sample counters must hold MAX_SAMPLES itself
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	// lower rank never exceeds ceil(MAX_SAMPLES/40)
	localparam int LOR_MAX = (MAX_SAMPLES + 39) / 40;
	localparam int LOR_W = $clog2(LOR_MAX + 1);
	// rank period of the 2.5% point
	localparam int RANK_DIV = 40;
	localparam int MOD_W = $clog2(RANK_DIV);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(RANK_DIV - 1);

	localparam logic signed [VAL_W-1:0] VAL_LARGEST = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_SMALLEST = {1'b1, {(VAL_W-1){1'b0}}};

	// item kinds
	localparam logic REQ_TALLY = 1'b0;
	localparam logic REQ_SORTED = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;

	// per group control for one item
	typedef struct packed {
		logic tally_clr; // new data set: totals and captures back to reset
		logic tally_inc; // count one sample of this group
		logic smp_inc;   // one sorted sample of this group
		logic var_clr;   // end of variable: seen count and captures back to reset
	} grp_ctl_t;

	// per group status, captures include the current sample
	typedef struct packed {
		logic few;
		val_t lo_val;
		val_t hi_val;
	} grp_stat_t;

	// merged range of one variable
	typedef struct packed {
		val_t range_low;
		val_t range_high;
		logic range_ok;
	} range_t;

endpackage

// File: rtl/core/gqor_if.sv
// Item channel interfaces: sample input and range result.
interface gqor_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic treated;
	logic [gqor_pkg::VAR_W-1:0] var_index;
	logic signed [gqor_pkg::VAL_W-1:0] sample_value;
	logic last_in_var;

	modport source (output valid, req_type, treated, var_index, sample_value, last_in_var,
		input ready);
	modport sink (input valid, req_type, treated, var_index, sample_value, last_in_var,
		output ready);
endinterface

interface gqor_out_if;
	logic valid;
	logic ready;
	logic [gqor_pkg::VAR_W-1:0] out_var;
	logic signed [gqor_pkg::VAL_W-1:0] range_low;
	logic signed [gqor_pkg::VAL_W-1:0] range_high;
	logic range_ok;
	logic overlap_so_far;

	modport source (output valid, out_var, range_low, range_high, range_ok, overlap_so_far,
		input ready);
	modport sink (input valid, out_var, range_low, range_high, range_ok, overlap_so_far,
		output ready);
endinterface

// File: rtl/core/gqor_group.sv
// One group's tally, rank counters, seen counter and quantile captures.
module gqor_group (
	input  logic                clk,
	input  logic                arst_n,
	input  gqor_pkg::grp_ctl_t  ctl,
	input  gqor_pkg::val_t      sample_value,
	output gqor_pkg::grp_stat_t stat
);

	localparam logic [gqor_pkg::MOD_W-1:0] MOD_ONE = gqor_pkg::MOD_W'(1);
	localparam logic [gqor_pkg::LOR_W-1:0] LOR_ONE = gqor_pkg::LOR_W'(1);

	logic [gqor_pkg::CNT_W-1:0] tot_q, tot_base, tot_n;
	logic [gqor_pkg::MOD_W-1:0] mod_q, mod_base, mod_n;
	logic [gqor_pkg::LOR_W-1:0] lor_q, lor_base, lor_n;
	logic [gqor_pkg::CNT_W-1:0] hir_q, hir_base, hir_n;
	logic [gqor_pkg::CNT_W-1:0] seen_q, seen_n;
	gqor_pkg::val_t lo_q, hi_q, lo_n, hi_n;

	// tally: ceil(n/40) steps when n leaves a multiple of 40, floor(39n/40) otherwise
	always_comb begin
		tot_base = ctl.tally_clr ? '0 : tot_q;
		mod_base = ctl.tally_clr ? '0 : mod_q;
		lor_base = ctl.tally_clr ? '0 : lor_q;
		hir_base = ctl.tally_clr ? '0 : hir_q;
		tot_n = tot_base;
		mod_n = mod_base;
		lor_n = lor_base;
		hir_n = hir_base;
		if (ctl.tally_inc && tot_base < gqor_pkg::CNT_MAX) begin
			tot_n = tot_base + gqor_pkg::CNT_ONE;
			mod_n = (mod_base == gqor_pkg::MOD_LAST) ? '0 : mod_base + MOD_ONE;
			if (mod_base == '0) begin
				lor_n = lor_base + LOR_ONE;
			end else begin
				hir_n = hir_base + gqor_pkg::CNT_ONE;
			end
		end
	end

	// rank match on the saturating seen count
	always_comb begin
		seen_n = seen_q;
		lo_n = lo_q;
		hi_n = hi_q;
		if (ctl.smp_inc) begin
			if (seen_q < gqor_pkg::CNT_MAX) begin
				seen_n = seen_q + gqor_pkg::CNT_ONE;
			end
			if (seen_n == gqor_pkg::CNT_W'(lor_q)) begin
				lo_n = sample_value;
			end
			if (seen_n == hir_q) begin
				hi_n = sample_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
			mod_q <= '0;
			lor_q <= '0;
			hir_q <= '0;
			seen_q <= '0;
			lo_q <= gqor_pkg::VAL_LARGEST;
			hi_q <= gqor_pkg::VAL_SMALLEST;
		end else begin
			tot_q <= tot_n;
			mod_q <= mod_n;
			lor_q <= lor_n;
			hir_q <= hir_n;
			if (ctl.tally_clr || ctl.var_clr) begin
				seen_q <= '0;
				lo_q <= gqor_pkg::VAL_LARGEST;
				hi_q <= gqor_pkg::VAL_SMALLEST;
			end else begin
				seen_q <= seen_n;
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
		end
	end

	assign stat.few = (tot_q <= gqor_pkg::CNT_ONE);
	assign stat.lo_val = lo_n;
	assign stat.hi_val = hi_n;

endmodule

// File: rtl/core/gqor_merge.sv
// Combines both groups' quantiles into the overlap range of a variable.
module gqor_merge (
	input  gqor_pkg::grp_stat_t trt,
	input  gqor_pkg::grp_stat_t ctrl,
	output gqor_pkg::range_t    range
);

	gqor_pkg::val_t lo_max, hi_min;

	// larger of the lows, smaller of the highs
	assign lo_max = (trt.lo_val < ctrl.lo_val) ? ctrl.lo_val : trt.lo_val;
	assign hi_min = (trt.hi_val < ctrl.hi_val) ? trt.hi_val : ctrl.hi_val;

	// a group of one sample or none reports the extreme codes
	always_comb begin
		if (trt.few || ctrl.few) begin
			range.range_low = gqor_pkg::VAL_LARGEST;
			range.range_high = gqor_pkg::VAL_SMALLEST;
			range.range_ok = 1'b0;
		end else begin
			range.range_low = lo_max;
			range.range_high = hi_min;
			range.range_ok = (lo_max < hi_min);
		end
	end

endmodule

// File: rtl/core/group_quantile_overlap_range.sv
// Each item is registered at the input, then updates the group counters and quantile
// captures as it advances, and a variable's range lands in the output register in that
// same cycle; one item is accepted per clock when not stalled. Tally items (req_type 0) count
// treated and control samples; the sorted samples of each variable follow in ascending
// order, and the one marked last_in_var yields the range result. A tally item arriving after
// any sorted sample starts a new data set. Input ready drops only while a result-producing
// item waits for the output register to be taken.
module group_quantile_overlap_range (
	input  logic              clk,
	input  logic              arst_n,
	gqor_in_if.sink           req,
	gqor_out_if.source        rsp
);

	// input stage
	logic valid_s1;
	logic req_type_s1, treated_s1, last_s1;
	logic [gqor_pkg::VAR_W-1:0] var_s1;
	gqor_pkg::val_t value_s1;

	logic adv, has_result, is_sorted;
	logic ranked_q, ovl_q, ovl_n;
	gqor_pkg::grp_ctl_t trt_ctl, ctrl_ctl;
	gqor_pkg::grp_stat_t trt_stat, ctrl_stat;
	gqor_pkg::range_t range;

	// output register
	logic out_valid_q;
	logic [gqor_pkg::VAR_W-1:0] out_var_q;
	gqor_pkg::val_t range_low_q, range_high_q;
	logic range_ok_q, overlap_q;

	assign is_sorted = (req_type_s1 == gqor_pkg::REQ_SORTED);
	assign has_result = is_sorted && last_s1;
	assign adv = valid_s1 && (!has_result || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			treated_s1 <= req.treated;
			var_s1 <= req.var_index;
			value_s1 <= req.sample_value;
			last_s1 <= req.last_in_var;
		end
	end

	// group controls
	always_comb begin
		trt_ctl.tally_clr = adv && !is_sorted && ranked_q;
		trt_ctl.tally_inc = adv && !is_sorted && treated_s1;
		trt_ctl.smp_inc = adv && is_sorted && treated_s1;
		trt_ctl.var_clr = adv && has_result;
		ctrl_ctl.tally_clr = trt_ctl.tally_clr;
		ctrl_ctl.tally_inc = adv && !is_sorted && !treated_s1;
		ctrl_ctl.smp_inc = adv && is_sorted && !treated_s1;
		ctrl_ctl.var_clr = trt_ctl.var_clr;
	end

	gqor_group u_trt (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(trt_ctl),
		.sample_value(value_s1),
		.stat(trt_stat)
	);

	gqor_group u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctrl_ctl),
		.sample_value(value_s1),
		.stat(ctrl_stat)
	);

	gqor_merge u_merge (
		.trt(trt_stat),
		.ctrl(ctrl_stat),
		.range(range)
	);

	assign ovl_n = ovl_q && range.range_ok;

	// phase and running overlap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranked_q <= 1'b0;
			ovl_q <= 1'b1;
		end else if (adv) begin
			ranked_q <= is_sorted;
			if (trt_ctl.tally_clr) begin
				ovl_q <= 1'b1;
			end else if (has_result) begin
				ovl_q <= ovl_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			out_var_q <= var_s1;
			range_low_q <= range.range_low;
			range_high_q <= range.range_high;
			range_ok_q <= range.range_ok;
			overlap_q <= ovl_n;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.out_var = out_var_q;
	assign rsp.range_low = range_low_q;
	assign rsp.range_high = range_high_q;
	assign rsp.range_ok = range_ok_q;
	assign rsp.overlap_so_far = overlap_q;

`ifndef ASSERT_OFF
	// a valid range is a nonempty interval
	a_ok_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_ok |-> (rsp.range_low < rsp.range_high))
		else $error("range_ok with range_low not below range_high");

	// the running flag cannot survive an invalid variable
	a_ovl_and: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.range_ok |-> !rsp.overlap_so_far)
		else $error("overlap_so_far set on an invalid range");

	// a tally item always leaves the ranked phase
	a_tally_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !is_sorted |=> !ranked_q)
		else $error("ranked phase kept after a tally item");
`endif

endmodule

// File: tb/sv/group_quantile_overlap_range_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for group_quantile_overlap_range: directed rows, stalls, random sets.
module group_quantile_overlap_range_tb;

	localparam int IDLE_PCT = 27;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 350;

	typedef struct packed {
		logic req_type;
		logic treated;
		logic [gqor_pkg::VAR_W-1:0] var_index;
		gqor_pkg::val_t value;
		logic last;
	} sample_t;

	typedef struct packed {
		logic [gqor_pkg::VAR_W-1:0] var_id;
		gqor_pkg::val_t low;
		gqor_pkg::val_t high;
		logic ok;
		logic overlap;
	} range_res_t;

	typedef struct packed {
		sample_t smp;
		logic typed;
		range_res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gqor_in_if req_if();
	gqor_out_if rsp_if();

	group_quantile_overlap_range dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// predictor state
	logic [gqor_pkg::CNT_W-1:0] trt_total, ctl_total, trt_seen, ctl_seen;
	gqor_pkg::val_t trt_lo, trt_hi, ctl_lo, ctl_hi;
	logic overlap_all, ranked;

	range_res_t pending_ranges[$];
	dir_row_t dir_rows[$];
	int errors;
	int samples_sent;
	bit no_idle;
	bit hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [gqor_pkg::CNT_W-1:0] sat_bump(
		input logic [gqor_pkg::CNT_W-1:0] c);
		return (c < gqor_pkg::CNT_MAX) ? c + gqor_pkg::CNT_ONE : c;
	endfunction

	function automatic void clear_captures();
		trt_seen = '0;
		ctl_seen = '0;
		trt_lo = gqor_pkg::VAL_LARGEST;
		ctl_lo = gqor_pkg::VAL_LARGEST;
		trt_hi = gqor_pkg::VAL_SMALLEST;
		ctl_hi = gqor_pkg::VAL_SMALLEST;
	endfunction

	// advance the predicted state by one item; returns 1 when a range comes out
	function automatic bit predict_range(input sample_t s, output range_res_t r);
		int unsigned n;
		logic [gqor_pkg::CNT_W-1:0] lo_rank, hi_rank;
		gqor_pkg::val_t lo, hi;
		logic ok;
		r = '0;
		if (s.req_type == gqor_pkg::REQ_TALLY) begin
			// first tally after sorted samples opens a new data set
			if (ranked) begin
				trt_total = '0;
				ctl_total = '0;
				clear_captures();
				overlap_all = 1'b1;
				ranked = 1'b0;
			end
			if (s.treated)
				trt_total = sat_bump(trt_total);
			else
				ctl_total = sat_bump(ctl_total);
			return 1'b0;
		end
		ranked = 1'b1;
		n = 32'(s.treated ? trt_total : ctl_total);
		lo_rank = gqor_pkg::CNT_W'((n + gqor_pkg::RANK_DIV - 1) / gqor_pkg::RANK_DIV);
		hi_rank = gqor_pkg::CNT_W'((n * (gqor_pkg::RANK_DIV - 1)) / gqor_pkg::RANK_DIV);
		if (s.treated) begin
			trt_seen = sat_bump(trt_seen);
			if (trt_seen == lo_rank) trt_lo = s.value;
			if (trt_seen == hi_rank) trt_hi = s.value;
		end else begin
			ctl_seen = sat_bump(ctl_seen);
			if (ctl_seen == lo_rank) ctl_lo = s.value;
			if (ctl_seen == hi_rank) ctl_hi = s.value;
		end
		if (!s.last)
			return 1'b0;
		// merge the two groups
		if (trt_total <= gqor_pkg::CNT_ONE || ctl_total <= gqor_pkg::CNT_ONE) begin
			lo = gqor_pkg::VAL_LARGEST;
			hi = gqor_pkg::VAL_SMALLEST;
			ok = 1'b0;
		end else begin
			lo = (trt_lo < ctl_lo) ? ctl_lo : trt_lo;
			hi = (trt_hi < ctl_hi) ? trt_hi : ctl_hi;
			ok = lo < hi;
		end
		if (!ok) overlap_all = 1'b0;
		r.var_id = s.var_index;
		r.low = lo;
		r.high = hi;
		r.ok = ok;
		r.overlap = overlap_all;
		clear_captures();
		return 1'b1;
	endfunction

	function automatic range_res_t few_range(input logic [gqor_pkg::VAR_W-1:0] vi);
		range_res_t r;
		r.var_id = vi;
		r.low = gqor_pkg::VAL_LARGEST;
		r.high = gqor_pkg::VAL_SMALLEST;
		r.ok = 1'b0;
		r.overlap = 1'b0;
		return r;
	endfunction

	function automatic void add_row(input logic rt, input logic trt,
		input logic [gqor_pkg::VAR_W-1:0] vi, input gqor_pkg::val_t v, input logic lst,
		input logic typed, input range_res_t want);
		dir_row_t row;
		row.smp.req_type = rt;
		row.smp.treated = trt;
		row.smp.var_index = vi;
		row.smp.value = v;
		row.smp.last = lst;
		row.typed = typed;
		row.want = want;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic int pick_group_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return $urandom_range(0, 1);
		if (r < 88) return $urandom_range(2, 12);
		return $urandom_range(40, 90);
	endfunction

	// offer one item, wait for the handshake, then log what it should produce
	task automatic send_sample(input sample_t s, input logic typed, input range_res_t want);
		range_res_t pred;
		bit produced;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= s.req_type;
		req_if.treated <= s.treated;
		req_if.var_index <= s.var_index;
		req_if.sample_value <= s.value;
		req_if.last_in_var <= s.last;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		samples_sent++;
		produced = predict_range(s, pred);
		if (typed)
			pending_ranges.insert(pending_ranges.size(), want);
		else if (produced)
			pending_ranges.insert(pending_ranges.size(), pred);
	endtask

	// sender holds back until every pending range is out
	task automatic pause_until_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_ranges.size() != 0);
	endtask

	// one data set: shuffled tallies, then a few variables of merged sorted samples
	task automatic run_data_set();
		int nt, nc, rt, rc, mt, mc, shape;
		longint acc;
		sample_t s;
		nt = pick_group_size();
		nc = pick_group_size();
		rt = nt;
		rc = nc;
		while (rt + rc > 0) begin
			s.req_type = gqor_pkg::REQ_TALLY;
			s.treated = (rc == 0) || (rt != 0 && $urandom_range(0, rt + rc - 1) < rt);
			s.var_index = gqor_pkg::VAR_W'($urandom());
			s.value = gqor_pkg::val_t'($urandom());
			s.last = 1'($urandom_range(0, 1));
			if (s.treated) rt--; else rc--;
			send_sample(s, 1'b0, '0);
		end
		repeat ($urandom_range(1, 4)) begin
			shape = $urandom_range(0, 9);
			mt = nt;
			mc = nc;
			// miscounted variable: groups come up short or long
			if (shape == 0) begin
				mt = $urandom_range(0, nt + 2);
				mc = $urandom_range(0, nc + 2);
			end
			if (mt + mc == 0) mt = 1;
			s.var_index = gqor_pkg::VAR_W'($urandom_range(0, 255));
			acc = ($urandom_range(0, 3) == 0) ? longint'(gqor_pkg::VAL_SMALLEST) :
				longint'(gqor_pkg::val_t'($urandom()));
			while (mt + mc > 0) begin
				s.req_type = gqor_pkg::REQ_SORTED;
				s.treated = (mc == 0) || (mt != 0 && $urandom_range(0, mt + mc - 1) < mt);
				if (s.treated) mt--; else mc--;
				// unsorted noise on one shape, ascending otherwise
				if (shape == 1) begin
					s.value = gqor_pkg::val_t'($urandom());
				end else begin
					acc += ($urandom_range(0, 9) == 0) ? longint'($urandom()) :
						longint'($urandom_range(0, 1000));
					if (acc > gqor_pkg::VAL_LARGEST) acc = gqor_pkg::VAL_LARGEST;
					s.value = gqor_pkg::val_t'(acc);
				end
				s.last = (mt + mc == 0);
				send_sample(s, 1'b0, '0);
			end
		end
	endtask

	// receiver: random stalls, quiet stretches and one long hold-off
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic flag_field(input string field, input logic signed [63:0] want_v,
		input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
		end
	endtask

	// result checker and progress watchdog
	initial begin
		int quiet_cycles;
		range_res_t want;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				if (pending_ranges.size() == 0) begin
					errors++;
					$display("%0t: unexpected range for var %0d", $time, rsp_if.out_var);
				end else begin
					want = pending_ranges.pop_front();
					flag_field("out_var", want.var_id, rsp_if.out_var);
					flag_field("range_low", want.low, rsp_if.range_low);
					flag_field("range_high", want.high, rsp_if.range_high);
					flag_field("range_ok", want.ok, rsp_if.range_ok);
					flag_field("overlap_so_far", want.overlap, rsp_if.overlap_so_far);
				end
			end
			if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
				(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
					$display("group_quantile_overlap_range test failed");
					$finish;
				end
			end
		end
	end

	// stimulus
	initial begin
		int start_items;
		sample_t s;
		errors = 0;
		samples_sent = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		trt_total = '0;
		ctl_total = '0;
		clear_captures();
		overlap_all = 1'b1;
		ranked = 1'b0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.req_type <= gqor_pkg::REQ_TALLY;
		req_if.treated <= 1'b0;
		req_if.var_index <= '0;
		req_if.sample_value <= '0;
		req_if.last_in_var <= 1'b0;

		// directed rows; typed expectations where the answer is plain
		// sorted sample straight after reset: both groups empty
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'hFF, 32'sd0, 1'b1, 1'b1, few_range(8'hFF));
		// one treated, two control; tally ignores var, value and last
		add_row(gqor_pkg::REQ_TALLY, 1'b1, 8'hAA, gqor_pkg::VAL_LARGEST, 1'b1, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b0, 8'h55, gqor_pkg::VAL_SMALLEST, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b0, 8'h00, -32'sd1, 1'b1, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b0, 8'd7, gqor_pkg::VAL_SMALLEST, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'd7, 32'sd5, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b0, 8'd7, 32'sd9, 1'b1, 1'b1, few_range(8'd7));
		// three per group: ranks 1 and 2 are captured
		add_row(gqor_pkg::REQ_TALLY, 1'b1, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b0, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b1, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b0, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b1, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_TALLY, 1'b0, 8'h00, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'd0, gqor_pkg::VAL_SMALLEST, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b0, 8'd0, -32'sd100, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'd0, 32'sd0, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b0, 8'd0, 32'sd100, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'd0, gqor_pkg::VAL_LARGEST, 1'b0, 1'b0, '0);
		add_row(gqor_pkg::REQ_SORTED, 1'b0, 8'd0, gqor_pkg::VAL_LARGEST, 1'b1, 1'b0, '0);
		// next variable ends after one treated sample: only the treated lower rank is reached
		add_row(gqor_pkg::REQ_SORTED, 1'b1, 8'd1, 32'sd5, 1'b1, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);

		// long receiver hold-off while a burst of result items keeps coming
		for (int i = 0; i < 6; i++) begin
			s.req_type = gqor_pkg::REQ_TALLY;
			s.treated = (i < 3);
			s.var_index = '0;
			s.value = '0;
			s.last = 1'b0;
			send_sample(s, 1'b0, '0);
		end
		hold_req = 1'b1;
		repeat (20) begin
			s.req_type = gqor_pkg::REQ_SORTED;
			s.treated = 1'($urandom_range(0, 1));
			s.var_index = gqor_pkg::VAR_W'($urandom());
			s.value = gqor_pkg::val_t'($urandom());
			s.last = 1'b1;
			send_sample(s, 1'b0, '0);
		end
		pause_until_drained();

		// data sets streamed back to back with no idling on either side
		start_items = samples_sent;
		no_idle = 1'b1;
		run_data_set();
		run_data_set();
		no_idle = 1'b0;
		pause_until_drained();

		// random data sets with some stray items and sender pauses
		while (samples_sent - start_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 8) begin
				s.req_type = 1'($urandom_range(0, 1));
				s.treated = 1'($urandom_range(0, 1));
				s.var_index = gqor_pkg::VAR_W'($urandom());
				s.value = gqor_pkg::val_t'($urandom());
				s.last = 1'($urandom_range(0, 1));
				send_sample(s, 1'b0, '0);
			end
			run_data_set();
			if ($urandom_range(0, 19) == 0) pause_until_drained();
		end

		// drain
		req_if.valid <= 1'b0;
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_ranges.size() == 0)
			$display("group_quantile_overlap_range test passed");
		else
			$display("group_quantile_overlap_range test failed");
		$finish;
	end

endmodule
